/* design/fmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types, constants and helpers of the 2x2 feature map pooling block.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int DATA_BITS  = 32;
  localparam int WINDOW     = 2;
  localparam int POOL_AREA  = WINDOW * WINDOW;
  localparam int POOL_SHIFT = $clog2(POOL_AREA);
  // a window sum needs two more bits than one sample
  localparam int ACC_W      = DATA_BITS + POOL_SHIFT;

  localparam int TDATA_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    POOL_MAX = 1'b0,
    POOL_AVG = 1'b1
  } pool_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_KIND     = 3'd0,
    REG_RECTIFY       = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_MAP_SIDE      = 3'd3,
    REG_IMAGES        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    pool_kind_e kind;
    logic       rectify;
  } cfg_t;

  // position flags of one request
  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic last;
  } tag_t;

  function automatic logic signed [ACC_W-1:0] combine(
    pool_kind_e              kind,
    logic signed [ACC_W-1:0] a,
    logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] res;
    if (kind == POOL_MAX) begin
      res = (a > b) ? a : b;
    end else begin
      res = a + b;
    end
    return res;
  endfunction

endpackage

/* design/fmp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fmp_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fmp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_ctrl
// Configuration registers and the channel, column, row and image counters
// that place each incoming sample and address the two stores.
// ----------------------------------------------------------------------------
module fmp_ctrl #(
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_SIDE     = 16,
  parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int RS_AW        = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fmp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                accept_i,
  output logic [CH_W-1:0]                     ch_o,
  output logic [RS_AW-1:0]                    rs_addr_o,
  output fmp_pkg::tag_t                       tag_o,
  output fmp_pkg::cfg_t                       cfg_o
);

  localparam int COL_W        = $clog2(MAX_SIDE);
  localparam int SIDE_TOP_MAX = MAX_SIDE - (MAX_SIDE % fmp_pkg::WINDOW) - 1;

  fmp_pkg::pool_kind_e pool_kind_q, pool_kind_d;
  logic                rectify_q, rectify_d;
  logic [5:0]          channel_count_q, channel_count_d;
  logic [4:0]          map_side_q, map_side_d;
  logic [15:0]         images_q, images_d;

  logic [CH_W-1:0]  ch_q, ch_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;
  logic [15:0]      img_q, img_d;

  logic [CH_W-1:0]  ch_top;
  logic [COL_W-1:0] side_top;
  logic [15:0]      img_top;
  logic             restart;

  // effective limits after clamping the register values
  always_comb begin
    if (channel_count_q == 6'd0) begin
      ch_top = '0;
    end else if (int'(channel_count_q) > MAX_CHANNELS) begin
      ch_top = CH_W'(MAX_CHANNELS - 1);
    end else begin
      ch_top = CH_W'(channel_count_q - 6'd1);
    end

    if (int'(map_side_q) < fmp_pkg::WINDOW) begin
      side_top = COL_W'(fmp_pkg::WINDOW - 1);
    end else if (int'(map_side_q) > MAX_SIDE) begin
      side_top = COL_W'(SIDE_TOP_MAX);
    end else begin
      side_top = COL_W'(map_side_q - 5'(map_side_q % fmp_pkg::WINDOW) - 5'd1);
    end

    img_top = (images_q == 16'd0) ? 16'd0 : images_q - 16'd1;
  end

  always_comb begin
    pool_kind_d     = pool_kind_q;
    rectify_d       = rectify_q;
    channel_count_d = channel_count_q;
    map_side_d      = map_side_q;
    images_d        = images_q;
    restart         = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fmp_pkg::REG_POOL_KIND: begin
          pool_kind_d = fmp_pkg::pool_kind_e'(cfg_data_i[0]);
          restart     = 1'b1;
        end
        fmp_pkg::REG_RECTIFY: begin
          rectify_d = cfg_data_i[0];
          restart   = 1'b1;
        end
        fmp_pkg::REG_CHANNEL_COUNT: begin
          channel_count_d = cfg_data_i[5:0];
          restart         = 1'b1;
        end
        fmp_pkg::REG_MAP_SIDE: begin
          map_side_d = cfg_data_i[4:0];
          restart    = 1'b1;
        end
        fmp_pkg::REG_IMAGES: begin
          images_d = cfg_data_i[15:0];
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ch_d  = ch_q;
    col_d = col_q;
    row_d = row_q;
    img_d = img_q;
    if (restart) begin
      ch_d  = '0;
      col_d = '0;
      row_d = '0;
      img_d = '0;
    end else if (accept_i) begin
      if (ch_q == ch_top) begin
        ch_d = '0;
        if (col_q == side_top) begin
          col_d = '0;
          if (row_q == side_top) begin
            row_d = '0;
            img_d = (img_q == img_top) ? 16'd0 : img_q + 16'd1;
          end else begin
            row_d = row_q + COL_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end else begin
        ch_d = ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_kind_q     <= fmp_pkg::POOL_AVG;
      rectify_q       <= 1'b0;
      channel_count_q <= 6'd32;
      map_side_q      <= 5'd16;
      images_q        <= 16'd1;
      ch_q            <= '0;
      col_q           <= '0;
      row_q           <= '0;
      img_q           <= '0;
    end else begin
      pool_kind_q     <= pool_kind_d;
      rectify_q       <= rectify_d;
      channel_count_q <= channel_count_d;
      map_side_q      <= map_side_d;
      images_q        <= images_d;
      ch_q            <= ch_d;
      col_q           <= col_d;
      row_q           <= row_d;
      img_q           <= img_d;
    end
  end

  assign ch_o          = ch_q;
  // one row store entry per channel per pooled column
  assign rs_addr_o     = RS_AW'(int'(col_q >> 1) * MAX_CHANNELS + int'(ch_q));
  assign tag_o.col_odd = col_q[0];
  assign tag_o.row_odd = row_q[0];
  assign tag_o.last    = (img_q == img_top) && (row_q == side_top) &&
                         (col_q == side_top) && (ch_q == ch_top);
  assign cfg_o.kind    = pool_kind_q;
  assign cfg_o.rectify = rectify_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_q <= ch_top) && (col_q <= side_top) && (row_q <= side_top))
    else $error("position counter beyond the configured map");

endmodule

/* design/fmp_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_reduce
// Read-modify-write pipeline: folds the window partial and the row store
// entry into each sample, writes the row store back and finishes the result.
// ----------------------------------------------------------------------------
module fmp_reduce #(
  parameter int RS_AW = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fmp_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [fmp_pkg::DATA_BITS-1:0]      sample_i,
  input  fmp_pkg::tag_t                      tag_i,
  input  logic [RS_AW-1:0]                   rs_addr_i,
  input  logic [fmp_pkg::ACC_W-1:0]          wp_rdata_i,
  input  logic [fmp_pkg::ACC_W-1:0]          rs_rdata_i,
  output logic                               rs_we_o,
  output logic [RS_AW-1:0]                   rs_waddr_o,
  output logic [fmp_pkg::ACC_W-1:0]          rs_wdata_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fmp_pkg::DATA_BITS-1:0]      out_data_o,
  output logic                               out_last_o
);

  localparam int ACC_W = fmp_pkg::ACC_W;
  localparam int EXT_W = ACC_W - fmp_pkg::DATA_BITS;

  // stage 1: store read data arrives
  logic                    valid1_q;
  logic signed [ACC_W-1:0] sample1_q;
  fmp_pkg::tag_t           tag1_q;
  logic [RS_AW-1:0]        addr1_q;
  // stage 2: window row segment folded
  logic                    valid2_q;
  logic signed [ACC_W-1:0] acc2_q;
  logic signed [ACC_W-1:0] rsd2_q;
  logic                    last2_q;
  // stage 3: full window folded
  logic                    valid3_q;
  logic signed [ACC_W-1:0] r3_q;
  logic                    last3_q;
  // output register
  logic                    out_valid_q;
  logic [fmp_pkg::DATA_BITS-1:0] out_data_q;
  logic                    out_last_q;

  logic signed [ACC_W-1:0] acc1;
  logic signed [ACC_W-1:0] r2;
  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] v3;
  logic                    goes_on;
  logic                    free1, free2, free3, free_out;

  assign goes_on  = tag1_q.col_odd && tag1_q.row_odd;
  assign free_out = !out_valid_q || out_ready_i;
  assign free3    = !valid3_q || free_out;
  assign free2    = !valid2_q || free3;
  assign free1    = !valid1_q || !goes_on || free2;

  assign acc1 = fmp_pkg::combine(cfg_i.kind, $signed(wp_rdata_i), sample1_q);
  assign r2   = fmp_pkg::combine(cfg_i.kind, rsd2_q, acc2_q);

  // average truncates toward zero: bias negative sums before the shift
  always_comb begin
    biased = r3_q;
    if (r3_q[ACC_W-1]) begin
      biased = r3_q + ACC_W'(fmp_pkg::POOL_AREA - 1);
    end
    v3 = r3_q;
    if (cfg_i.kind == fmp_pkg::POOL_AVG) begin
      v3 = biased >>> fmp_pkg::POOL_SHIFT;
    end
    if (cfg_i.rectify && v3[ACC_W-1]) begin
      v3 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      valid3_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free1) begin
        valid1_q <= in_valid_i;
      end
      if (free2) begin
        valid2_q <= valid1_q && goes_on;
      end
      if (free3) begin
        valid3_q <= valid2_q;
      end
      if (free_out) begin
        out_valid_q <= valid3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free1 && in_valid_i) begin
      sample1_q <= {{EXT_W{sample_i[fmp_pkg::DATA_BITS-1]}}, sample_i};
      tag1_q    <= tag_i;
      addr1_q   <= rs_addr_i;
    end
    if (free2 && valid1_q && goes_on) begin
      acc2_q  <= acc1;
      rsd2_q  <= $signed(rs_rdata_i);
      last2_q <= tag1_q.last;
    end
    if (free3 && valid2_q) begin
      r3_q    <= r2;
      last3_q <= last2_q;
    end
    if (free_out && valid3_q) begin
      out_data_q <= v3[fmp_pkg::DATA_BITS-1:0];
      out_last_q <= last3_q;
    end
  end

  // first row of a window pair parks its partial in the row store
  assign rs_we_o     = valid1_q && tag1_q.col_odd && !tag1_q.row_odd;
  assign rs_waddr_o  = addr1_q;
  assign rs_wdata_o  = acc1;

  assign in_ready_o  = free1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_ready_blocked_by_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> valid1_q && goes_on)
    else $error("input stalled with no waiting window item");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid2_q && !free3 |=> valid2_q && $stable(acc2_q) && $stable(rsd2_q))
    else $error("stage 2 lost its operands under stall");

  a_s3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid3_q && !free_out |=> valid3_q && $stable(r3_q) && $stable(last3_q))
    else $error("stage 3 lost its window result under stall");

endmodule

/* design/feature_map_pool_2x2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_map_pool_2x2
// Streaming 2x2 max or average pooling of square multi-channel feature maps.
// ----------------------------------------------------------------------------
// Samples enter one per cycle (channel fastest, then column, row, image) and
// the block sustains one sample per clock. The window store takes one access
// per sample (a write on even columns, a read on odd ones) and the row store
// a read on the request side and a write one stage later, so neither store
// limits the rate. s_axis_tready drops only while the request that completes
// a window waits behind a full result pipeline held by m_axis_tready. The
// sample completing a window passes stages 1, 2 and 3 of the reduce pipeline
// and its output register, whose valid drives m_axis_tvalid. Values come out in
// pooled row, pooled column, channel order, with tlast on the last value of
// the batch. The window store keeps one partial per channel and the row
// store one per channel per pooled column; both are always written before
// they are read, so reset needs no clearing pass. A write to any of the five
// configuration registers restarts the batch at its first sample.
module feature_map_pool_2x2 #(
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_SIDE     = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fmp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fmp_pkg::TDATA_W-1:0]       s_axis_tdata,  // [31:0] sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fmp_pkg::TDATA_W-1:0]       m_axis_tdata,  // [31:0] pooled_value
  output logic                              m_axis_tlast   // final_flag
);

  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RS_DEPTH = MAX_CHANNELS * (MAX_SIDE / fmp_pkg::WINDOW);
  localparam int RS_AW    = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
  localparam int ACC_W    = fmp_pkg::ACC_W;
  localparam int EXT_W    = ACC_W - fmp_pkg::DATA_BITS;

  logic              accept;
  logic [CH_W-1:0]   ch;
  logic [RS_AW-1:0]  rs_addr;
  fmp_pkg::tag_t     tag;
  fmp_pkg::cfg_t     cfg;
  logic [ACC_W-1:0]  wp_wdata;
  logic [ACC_W-1:0]  wp_rdata;
  logic [ACC_W-1:0]  rs_rdata;
  logic              rs_we;
  logic [RS_AW-1:0]  rs_waddr;
  logic [ACC_W-1:0]  rs_wdata;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign wp_wdata = {{EXT_W{s_axis_tdata[fmp_pkg::DATA_BITS-1]}},
                     s_axis_tdata[fmp_pkg::DATA_BITS-1:0]};

  fmp_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SIDE     (MAX_SIDE),
    .CH_W         (CH_W),
    .RS_AW        (RS_AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .ch_o        (ch),
    .rs_addr_o   (rs_addr),
    .tag_o       (tag),
    .cfg_o       (cfg)
  );

  // window store: even column writes the sample, odd column reads it back
  fmp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_W)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !tag.col_odd),
    .waddr_i (ch),
    .wdata_i (wp_wdata),
    .re_i    (accept && tag.col_odd),
    .raddr_i (ch),
    .rdata_o (wp_rdata)
  );

  // row store: even window row writes, odd window row reads
  fmp_ram #(
    .WIDTH (ACC_W),
    .DEPTH (RS_DEPTH),
    .AW    (RS_AW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .re_i    (accept && tag.col_odd && tag.row_odd),
    .raddr_i (rs_addr),
    .rdata_o (rs_rdata)
  );

  fmp_reduce #(
    .RS_AW (RS_AW)
  ) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[fmp_pkg::DATA_BITS-1:0]),
    .tag_i       (tag),
    .rs_addr_i   (rs_addr),
    .wp_rdata_i  (wp_rdata),
    .rs_rdata_i  (rs_rdata),
    .rs_we_o     (rs_we),
    .rs_waddr_o  (rs_waddr),
    .rs_wdata_o  (rs_wdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_map_pool_2x2 testbench
// Drives sample streams through the pooling block under a range of register
// settings and checks every pooled value and its tlast flag against an
// in-bench predictor of the window and row stores.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_CHANNELS = 32;
  localparam int MAX_SIDE     = 16;
  localparam int STORE_DEPTH  = MAX_CHANNELS * MAX_SIDE / fmp_pkg::WINDOW;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [fmp_pkg::ACC_W-1:0] acc_t;

  typedef struct {
    logic [fmp_pkg::DATA_BITS-1:0] value;
    logic                          is_last;
  } pool_result_t;

  class pool_scoreboard;
    fmp_pkg::pool_kind_e kind;
    bit                  rectify;
    bit [5:0]            chan_reg;
    bit [4:0]            side_reg;
    bit [15:0]           img_reg;
    acc_t                row_store [STORE_DEPTH];
    acc_t                win_store [MAX_CHANNELS];
    int unsigned         ch_pos, col_pos, row_pos, img_pos;
    pool_result_t        expected_pool_q [$];
    int                  errors;
    int                  results_seen;

    function new();
      kind     = fmp_pkg::POOL_AVG;
      rectify  = 1'b0;
      chan_reg = 6'd32;
      side_reg = 5'd16;
      img_reg  = 16'd1;
      errors   = 0;
      results_seen = 0;
      restart();
    endfunction

    function acc_t neutral();
      acc_t n;
      if (kind == fmp_pkg::POOL_MAX) begin
        n = {{(fmp_pkg::ACC_W - fmp_pkg::DATA_BITS + 1){1'b1}},
             {(fmp_pkg::DATA_BITS - 1){1'b0}}};
      end else begin
        n = '0;
      end
      return n;
    endfunction

    function acc_t merge_pair(acc_t a, acc_t b);
      if (kind == fmp_pkg::POOL_MAX) begin
        return (a > b) ? a : b;
      end
      return a + b;
    endfunction

    function void restart();
      foreach (row_store[i]) row_store[i] = neutral();
      foreach (win_store[i]) win_store[i] = neutral();
      ch_pos  = 0;
      col_pos = 0;
      row_pos = 0;
      img_pos = 0;
    endfunction

    function void apply_reg(fmp_pkg::cfg_reg_e idx, logic [15:0] val);
      case (idx)
        fmp_pkg::REG_POOL_KIND:     kind = fmp_pkg::pool_kind_e'(val[0]);
        fmp_pkg::REG_RECTIFY:       rectify = val[0];
        fmp_pkg::REG_CHANNEL_COUNT: chan_reg = val[5:0];
        fmp_pkg::REG_MAP_SIDE:      side_reg = val[4:0];
        fmp_pkg::REG_IMAGES:        img_reg = val;
        default: return;
      endcase
      restart();
    endfunction

    function int pending();
      return expected_pool_q.size();
    endfunction

    // advance the stores by one accepted sample request
    function void note_sample(logic [fmp_pkg::DATA_BITS-1:0] raw);
      int unsigned  chans, side, batch, idx;
      acc_t         s, acc, r, v;
      pool_result_t res;
      chans = (chan_reg == 0) ? 1 : (chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg;
      side  = side_reg;
      if (side < fmp_pkg::WINDOW) side = fmp_pkg::WINDOW;
      if (side > MAX_SIDE) side = MAX_SIDE;
      side  = side - (side % fmp_pkg::WINDOW);
      batch = (img_reg == 0) ? 1 : img_reg;
      s     = {{(fmp_pkg::ACC_W - fmp_pkg::DATA_BITS){raw[fmp_pkg::DATA_BITS-1]}}, raw};
      idx   = (col_pos / fmp_pkg::WINDOW) * MAX_CHANNELS + ch_pos;
      acc   = merge_pair(win_store[ch_pos], s);
      if ((col_pos % fmp_pkg::WINDOW) == fmp_pkg::WINDOW - 1) begin
        r = merge_pair(row_store[idx], acc);
        win_store[ch_pos] = neutral();
        if ((row_pos % fmp_pkg::WINDOW) == fmp_pkg::WINDOW - 1) begin
          v = r;
          // signed division truncates toward zero
          if (kind != fmp_pkg::POOL_MAX) v = r / fmp_pkg::POOL_AREA;
          if (rectify && v < 0) v = '0;
          res.value   = v[fmp_pkg::DATA_BITS-1:0];
          res.is_last = (img_pos + 1 >= batch) && (row_pos + 1 == side) &&
                        (col_pos + 1 == side) && (ch_pos + 1 == chans);
          expected_pool_q.push_back(res);
          row_store[idx] = neutral();
        end else begin
          row_store[idx] = r;
        end
      end else begin
        win_store[ch_pos] = acc;
      end
      ch_pos++;
      if (ch_pos >= chans) begin
        ch_pos = 0;
        col_pos++;
        if (col_pos >= side) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= side) begin
            row_pos = 0;
            img_pos++;
            if (img_pos >= batch) img_pos = 0;
          end
        end
      end
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_result(logic [fmp_pkg::DATA_BITS-1:0] value, logic is_last);
      pool_result_t exp_res;
      results_seen++;
      if (expected_pool_q.size() == 0) begin
        report($sformatf("unexpected pooled value %h last %b", value, is_last));
        return;
      end
      exp_res = expected_pool_q.pop_front();
      if (value !== exp_res.value) begin
        report($sformatf("pooled value %h, want %h (result %0d)",
                         value, exp_res.value, results_seen));
      end
      if (is_last !== exp_res.is_last) begin
        report($sformatf("tlast %b, want %b (result %0d)",
                         is_last, exp_res.is_last, results_seen));
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [fmp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fmp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [fmp_pkg::TDATA_W-1:0]    s_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_tready = 1'b0;
  logic [fmp_pkg::TDATA_W-1:0]    m_axis_tdata;
  logic                           m_axis_tlast;

  pool_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycles = 0;
  int samples_sent = 0;
  int settings_used = 0;

  // one window each, c=1 side 2: saturating, most negative, truncation cases
  logic [31:0] avg_cases [20] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
    32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000
  };
  logic [31:0] max_rect_cases [4] = '{
    32'hFFFF_FFFB, 32'hFFFF_FFFD, 32'hFFFF_FFF9, 32'hFFFF_FFF7
  };

  feature_map_pool_2x2 #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_SIDE    (MAX_SIDE)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL feature_map_pool_2x2");
      $finish;
    end
  end

  // result side: check, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom();
    if (sel < 85) return $urandom_range(15) - 8;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      default: return 32'h8000_0001;
    endcase
  endfunction

  task automatic send_sample(logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(v);
    samples_sent++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_sample(pick_sample());
  endtask

  // stop offering, drain all expected results, then let the pipeline empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(fmp_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    sb.apply_reg(idx, val);
  endtask

  task automatic program_regs(fmp_pkg::pool_kind_e kind, bit rect, int chans, int side,
                              int imgs);
    wait_idle();
    write_reg(fmp_pkg::REG_POOL_KIND, 16'(kind));
    write_reg(fmp_pkg::REG_RECTIFY, 16'(rect));
    write_reg(fmp_pkg::REG_CHANNEL_COUNT, 16'(chans));
    write_reg(fmp_pkg::REG_MAP_SIDE, 16'(side));
    write_reg(fmp_pkg::REG_IMAGES, 16'(imgs));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle(0, 0);
    program_regs(fmp_pkg::POOL_AVG, 1'b0, 1, 2, 1);
    foreach (avg_cases[i]) send_sample(avg_cases[i]);
    program_regs(fmp_pkg::POOL_MAX, 1'b1, 1, 2, 1);
    foreach (max_rect_cases[i]) send_sample(max_rect_cases[i]);

    program_regs(fmp_pkg::POOL_AVG, 1'b0, 3, 4, 2);
    send_random(96);

    set_idle(56, 0);
    program_regs(fmp_pkg::POOL_MAX, 1'b1, 1, 16, 1);
    send_random(256);

    // long receiver hold while the sender keeps pushing
    set_idle(0, 56);
    program_regs(fmp_pkg::POOL_MAX, 1'b0, 32, 2, 2);
    hold_request = HOLD_CYCLES;
    send_random(256);

    // out of range channel count, side and empty batch
    set_idle(27, 27);
    program_regs(fmp_pkg::POOL_AVG, 1'b1, 0, 3, 0);
    send_random(120);

    set_idle(0, 0);
    program_regs(fmp_pkg::POOL_AVG, 1'b0, 63, 1, 65535);
    send_random(256);

    set_idle(56, 0);
    program_regs(fmp_pkg::POOL_MAX, 1'b0, 2, 31, 1);
    send_random(200);

    set_idle(0, 56);
    program_regs(fmp_pkg::POOL_AVG, 1'b1, 5, 6, 2);
    send_random(360);

    set_idle(27, 27);
    program_regs(fmp_pkg::POOL_MAX, 1'b1, 4, 0, 1);
    send_random(64);

    wait_idle();
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d pooled values never arrived", sb.pending()));
    end
    $display("sent %0d samples under %0d register settings, checked %0d pooled values",
             samples_sent, settings_used, sb.results_seen);
    $display("max and average pooling, rectification, clamped sizes and a long output hold");
    if (sb.errors == 0) begin
      $display("PASS feature_map_pool_2x2");
    end else begin
      $display("FAIL feature_map_pool_2x2");
    end
    $finish;
  end

endmodule
